>>> rtl/core/lld_pkg.sv
package lld_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int WID_W       = $clog2(MAX_WORKERS);
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
  localparam int LOAD_W      = 8;
  localparam int JOB_W       = 7;
  localparam int MAX_JOBS    = 64;
  localparam int COOKS_W     = 7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_COOKS   = '0;
  localparam logic [COOKS_W-1:0] COOKS_RESET = COOKS_W'(1);

  typedef enum logic {
    OP_DISPATCH = 1'b0,
    OP_COMPLETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_CAP = 2'd1,
    ST_BAD    = 2'd2
  } status_t;

  typedef struct packed {
    logic              op;
    logic [JOB_W-1:0]  job_count;
    logic [WID_W-1:0]  worker_id;
  } req_t;

  typedef struct packed {
    logic [WID_W-1:0] assigned_worker;
    logic             new_worker;
    status_t          status;
    logic             last;
  } rsp_t;

  typedef struct packed {
    op_t              op;
    logic [JOB_W-1:0] jobs;
    logic [WID_W-1:0] wid;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT,
    BK_COMPL
  } back_state_t;

endpackage

>>> rtl/core/lld_front.sv
module lld_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lld_pkg::req_t  req,
  input  lld_pkg::q_stat_t q_stat,
  output logic           push,
  output lld_pkg::cmd_t  cmd
);

  logic          held;
  lld_pkg::cmd_t cmd_next;
  logic          accept;

  assign req_stall = held && q_stat.full;
  assign accept    = req_valid && !req_stall;
  assign push      = held && !q_stat.full;

  always_comb begin
    cmd_next.op  = lld_pkg::op_t'(req.op);
    cmd_next.wid = req.worker_id;
    if (req.job_count > lld_pkg::JOB_W'(lld_pkg::MAX_JOBS)) begin
      cmd_next.jobs = lld_pkg::JOB_W'(lld_pkg::MAX_JOBS);
    end else begin
      cmd_next.jobs = req.job_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

>>> rtl/core/lld_queue.sv
module lld_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lld_pkg::cmd_t    push_data,
  input  logic             pop,
  output lld_pkg::cmd_t    pop_data,
  output lld_pkg::q_stat_t q_stat
);

  lld_pkg::cmd_t                entries [lld_pkg::QUEUE_DEPTH];
  logic [lld_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lld_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lld_pkg::QCNT_W-1:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign q_stat.full  = (count == lld_pkg::QCNT_W'(lld_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/core/lld_back.sv
module lld_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lld_pkg::COOKS_W-1:0]  cooks,
  input  lld_pkg::q_stat_t             q_stat,
  input  lld_pkg::cmd_t                cmd_in,
  output logic                         pop,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output lld_pkg::rsp_t                rsp
);

  lld_pkg::back_state_t state, state_next;

  logic [lld_pkg::LOAD_W-1:0] load [lld_pkg::MAX_WORKERS];
  logic [lld_pkg::CNT_W-1:0]  active;
  logic [lld_pkg::CNT_W-1:0]  idx;
  logic [lld_pkg::LOAD_W-1:0] best;
  logic [lld_pkg::WID_W-1:0]  chosen;
  logic                       found;
  logic [lld_pkg::JOB_W-1:0]  jobs_left;
  logic [lld_pkg::WID_W-1:0]  wid;

  logic [lld_pkg::LOAD_W-1:0] limit;
  logic [lld_pkg::WID_W-1:0]  rd_addr;
  logic [lld_pkg::LOAD_W-1:0] rd_load;
  logic                       out_free;
  logic                       scan_step;
  logic                       emit_go;
  logic                       compl_go;
  logic                       restart;
  logic                       act_inc;
  logic                       wr_en;
  logic [lld_pkg::WID_W-1:0]  wr_addr;
  logic [lld_pkg::LOAD_W-1:0] wr_data;
  logic                       bad;
  lld_pkg::rsp_t              res;

  assign limit    = lld_pkg::LOAD_W'({cooks, 1'b0});
  assign out_free = !rsp_valid || !rsp_stall;
  assign rd_load  = load[rd_addr];

  always_comb begin
    state_next = state;
    unique case (state)
      lld_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          if (cmd_in.op == lld_pkg::OP_COMPLETE) begin
            state_next = lld_pkg::BK_COMPL;
          end else if (cmd_in.jobs != '0) begin
            state_next = lld_pkg::BK_SCAN;
          end
        end
      end
      lld_pkg::BK_SCAN: begin
        if (idx == active) begin
          state_next = lld_pkg::BK_EMIT;
        end
      end
      lld_pkg::BK_EMIT: begin
        if (out_free) begin
          state_next = (jobs_left == lld_pkg::JOB_W'(1)) ? lld_pkg::BK_IDLE
                                                         : lld_pkg::BK_SCAN;
        end
      end
      lld_pkg::BK_COMPL: begin
        if (out_free) begin
          state_next = lld_pkg::BK_IDLE;
        end
      end
      default: state_next = lld_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    scan_step = 1'b0;
    emit_go   = 1'b0;
    compl_go  = 1'b0;
    act_inc   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = chosen;
    wr_data   = '0;
    rd_addr   = chosen;
    bad       = 1'b0;
    res.assigned_worker = '0;
    res.new_worker      = 1'b0;
    res.status          = lld_pkg::ST_OK;
    res.last            = (jobs_left == lld_pkg::JOB_W'(1));
    unique case (state)
      lld_pkg::BK_IDLE: begin
        pop = !q_stat.empty;
      end
      lld_pkg::BK_SCAN: begin
        rd_addr   = idx[lld_pkg::WID_W-1:0];
        scan_step = (idx != active);
      end
      lld_pkg::BK_EMIT: begin
        emit_go = out_free;
        if (found) begin
          res.assigned_worker = chosen;
          wr_en   = out_free;
          wr_addr = chosen;
          wr_data = lld_pkg::LOAD_W'(rd_load + 1'b1);
        end else if (active < lld_pkg::CNT_W'(lld_pkg::MAX_WORKERS)) begin
          res.assigned_worker = active[lld_pkg::WID_W-1:0];
          res.new_worker      = 1'b1;
          wr_en   = out_free;
          wr_addr = active[lld_pkg::WID_W-1:0];
          wr_data = lld_pkg::LOAD_W'(1);
          act_inc = out_free;
        end else begin
          res.status = lld_pkg::ST_NO_CAP;
        end
      end
      lld_pkg::BK_COMPL: begin
        compl_go = out_free;
        rd_addr  = wid;
        bad      = (lld_pkg::CNT_W'(wid) >= active) || (rd_load == '0);
        res.assigned_worker = wid;
        res.last            = 1'b1;
        res.status          = bad ? lld_pkg::ST_BAD : lld_pkg::ST_OK;
        wr_en   = out_free && !bad;
        wr_addr = wid;
        wr_data = lld_pkg::LOAD_W'(rd_load - 1'b1);
      end
      default: begin
      end
    endcase
  end

  assign restart = pop || (emit_go && !res.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lld_pkg::BK_IDLE;
      active    <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < lld_pkg::MAX_WORKERS; i++) begin
        load[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (act_inc) begin
        active <= active + 1'b1;
      end
      if (wr_en) begin
        load[wr_addr] <= wr_data;
      end
      if (emit_go || compl_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      jobs_left <= cmd_in.jobs;
      wid       <= cmd_in.wid;
    end else if (emit_go) begin
      jobs_left <= jobs_left - 1'b1;
    end
    if (restart) begin
      idx    <= '0;
      best   <= limit;
      found  <= 1'b0;
      chosen <= '0;
    end else if (scan_step) begin
      idx <= idx + 1'b1;
      if (rd_load < best) begin
        best   <= rd_load;
        chosen <= idx[lld_pkg::WID_W-1:0];
        found  <= 1'b1;
      end
    end
    if (emit_go || compl_go) begin
      rsp <= res;
    end
  end

  a_open_grows: assert property (@(posedge clk) disable iff (rst)
    act_inc |=> active == lld_pkg::CNT_W'($past(active) + 1'b1))
    else $error("worker count did not advance on open");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == lld_pkg::ST_NO_CAP
      |-> active == lld_pkg::CNT_W'(lld_pkg::MAX_WORKERS))
    else $error("job dropped with free worker slots");

  a_new_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.new_worker |-> rsp.status == lld_pkg::ST_OK)
    else $error("new worker word with bad status");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == lld_pkg::BK_SCAN |-> idx <= active)
    else $error("scan index past active workers");

endmodule

>>> rtl/core/least_loaded_worker_dispatch.sv
// Channel   Direction  Word            Handshake
// req       in         lld_pkg::req_t  req_valid / req_stall
// rsp       out        lld_pkg::rsp_t  rsp_valid / rsp_stall
// apb       in         cooks_per_worker at byte address 0
//
// For each job of a dispatch request the load table is scanned
// one worker per cycle through its single read port, then the choice is issued.
// Each queued request is popped first; a completion is then answered when the output is free.
// req is taken every cycle while the 4-entry queue has room.
// Synchronous reset clears all loads, the worker count and the queue,
// and sets cooks_per_worker to 1.
module least_loaded_worker_dispatch (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  lld_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output lld_pkg::rsp_t                rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lld_pkg::PADDR_W-1:0]  paddr,
  input  logic [lld_pkg::PDATA_W-1:0]  pwdata,
  output logic [lld_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [lld_pkg::COOKS_W-1:0] cooks;
  logic                        sel_cooks;
  logic                        push;
  logic                        pop;
  lld_pkg::cmd_t               front_cmd;
  lld_pkg::cmd_t               queue_cmd;
  lld_pkg::q_stat_t            q_stat;

  assign pready    = 1'b1;
  assign sel_cooks = (paddr[lld_pkg::PADDR_W-1:2] == lld_pkg::REG_COOKS);
  assign prdata    = sel_cooks ? lld_pkg::PDATA_W'(cooks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cooks <= lld_pkg::COOKS_RESET;
    end else if (psel && penable && pwrite && pready && sel_cooks) begin
      cooks <= pwdata[lld_pkg::COOKS_W-1:0];
    end
  end

  lld_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (front_cmd)
  );

  lld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .pop       (pop),
    .pop_data  (queue_cmd),
    .q_stat    (q_stat)
  );

  lld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cooks     (cooks),
    .q_stat    (q_stat),
    .cmd_in    (queue_cmd),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
